>>> design/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Transaction payload structs, command and register codes, character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int IDX_W      = 11;  // cell index / cursor position width
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_NULL      = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  typedef struct packed {
    logic              command;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_position;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attribute;
    logic              scrolled;
  } tcw_out_t;

  // status from the index divider
  typedef struct packed {
    logic done;
    logic in_range;
  } tcw_div_status_t;

endpackage

>>> design/tcw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_div: cell index to row / column splitter
// Repeated subtraction of COLUMNS, one step per cycle, stopping at the last row.
// ----------------------------------------------------------------------------
module tcw_div import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CW     = $clog2(COLUMNS),
  localparam int RW     = $clog2(ROWS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IDX_W-1:0] index_i,
  output tcw_div_status_t  status_o,
  output logic [RW-1:0]    row_o,
  output logic [CW-1:0]    col_o
);

  localparam logic [IDX_W-1:0] COLS_K   = IDX_W'(COLUMNS);
  localparam logic [RW-1:0]    LAST_ROW = RW'(ROWS - 1);

  logic             busy_q;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [RW-1:0]    cnt_q, cnt_d;
  logic             fits;

  // remainder below one row: quotient found
  assign fits = (rem_q < COLS_K);

  assign status_o.done     = busy_q && (fits || (cnt_q == LAST_ROW));
  assign status_o.in_range = fits;
  assign row_o             = cnt_q;
  assign col_o             = CW'(rem_q);

  // subtract step
  always_comb begin
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = index_i;
      cnt_d = '0;
    end else if (busy_q && !status_o.done) begin
      rem_d = rem_q - COLS_K;
      cnt_d = cnt_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (status_o.done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

endmodule

>>> design/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: text-mode screen store with cursor
// Character/attribute cell memory, put and read commands, scroll by a
// circular top-row pointer so a scroll only clears one row.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         cmd_i    (tcw_in_t)
//  result    done_o (1 cycle)     result_o (tcw_out_t)
//  config    cfg_we_i             cfg_idx_i, cfg_data_i
//
// Steps: a printable put writes its cell, a backspace blanks the cell before the
// cursor, a newline writes cells to the end of the line, a put that scrolls then
// clears the new bottom row, and a read runs the divider steps plus a registered
// memory read. One cell memory port write per cycle sets the fill and clear times.
// Reset: a clearing pass writes every cell, busy high.
// The receiver cannot stall: each result is shown for one cycle on done_o.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  tcw_in_t               cmd_i,
  output logic                  done_o,
  output tcw_out_t              result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NCELLS = COLUMNS * ROWS;
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int LW     = $clog2(NCELLS);
  localparam int DEPTH  = 2 ** (RW + CW);

  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [LW-1:0] BOTTOM_LIN = LW'(NCELLS - COLUMNS);

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WRITE  = 4'd2;
  localparam logic [3:0] S_BSWR   = 4'd3;
  localparam logic [3:0] S_SCROLL = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_RD     = 4'd6;
  localparam logic [3:0] S_RDOUT  = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0]        state_q;
  logic [ATTR_W-1:0] text_color_q, blank_attr_q;

  // cursor: logical row, physical row, column, linear index
  logic [RW-1:0]     cur_row_q, cur_prow_q, top_q;
  logic [CW-1:0]     cur_col_q;
  logic [LW-1:0]     lin_q;
  logic              fill_q;
  logic [CHAR_W-1:0] code_q;

  logic [RW-1:0]     rd_prow_q;
  logic [CW-1:0]     rd_col_q;
  logic [15:0]       rdata_q;
  logic [CHAR_W-1:0] rchar_q;
  logic [ATTR_W-1:0] rattr_q;
  logic              scroll_q;

  logic [15:0]       mem [DEPTH];
  logic              mem_we;
  logic [15:0]       mem_wdata;

  logic              accept;
  tcw_div_status_t   div_st;
  logic [RW-1:0]     div_row;
  logic [CW-1:0]     div_col;
  logic [RW:0]       rd_sum;
  logic [RW-1:0]     rd_prow_d;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // result port
  assign done_o                   = (state_q == S_FINISH);
  assign result_o.cursor_position = IDX_W'(lin_q);
  assign result_o.read_char       = rchar_q;
  assign result_o.read_attribute  = rattr_q;
  assign result_o.scrolled        = scroll_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_ATTR;
      blank_attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TEXT_COLOR) text_color_q <= cfg_data_i;
      if (cfg_idx_i == REG_BLANK_ATTR) blank_attr_q <= cfg_data_i;
    end
  end

  // index divider for reads
  tcw_div #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && (cmd_i.command == CMD_READ)),
    .index_i  (cmd_i.cell_index),
    .status_o (div_st),
    .row_o    (div_row),
    .col_o    (div_col)
  );

  // logical to physical row for reads
  assign rd_sum    = (RW + 1)'(div_row) + (RW + 1)'(top_q);
  assign rd_prow_d = (rd_sum >= (RW + 1)'(ROWS)) ? RW'(rd_sum - (RW + 1)'(ROWS))
                                                  : RW'(rd_sum);

  // write data per state
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {RESET_ATTR, CHAR_NULL};
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = {blank_attr_q, CHAR_NULL};
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = {text_color_q, fill_q ? CHAR_SPACE : code_q};
      end
      S_BSWR: begin
        mem_we    = 1'b1;
        mem_wdata = {text_color_q, CHAR_SPACE};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // cell memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[{cur_prow_q, cur_col_q}] <= mem_wdata;
    rdata_q <= mem[{rd_prow_q, rd_col_q}];
  end

  // sequencer and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cur_row_q  <= '0;
      cur_prow_q <= '0;
      cur_col_q  <= '0;
      lin_q      <= '0;
      top_q      <= '0;
      fill_q     <= 1'b0;
      scroll_q   <= 1'b0;
    end else begin
      case (state_q)
        // sweep all physical cells after reset
        S_CLEAR: begin
          if (cur_col_q == LAST_COL) begin
            cur_col_q <= '0;
            if (cur_prow_q == LAST_ROW) begin
              cur_prow_q <= '0;
              state_q    <= S_IDLE;
            end else begin
              cur_prow_q <= cur_prow_q + RW'(1);
            end
          end else begin
            cur_col_q <= cur_col_q + CW'(1);
          end
        end

        S_IDLE: begin
          if (accept) begin
            scroll_q <= 1'b0;
            if (cmd_i.command == CMD_READ) begin
              state_q <= S_DIV;
            end else if (cmd_i.char_code == CHAR_BACKSPACE) begin
              if (lin_q == '0) begin
                state_q <= S_FINISH;
              end else begin
                // step back one cell, then blank it
                lin_q <= lin_q - LW'(1);
                if (cur_col_q == '0) begin
                  cur_col_q  <= LAST_COL;
                  cur_row_q  <= cur_row_q - RW'(1);
                  cur_prow_q <= (cur_prow_q == '0) ? LAST_ROW : cur_prow_q - RW'(1);
                end else begin
                  cur_col_q <= cur_col_q - CW'(1);
                end
                state_q <= S_BSWR;
              end
            end else begin
              fill_q  <= (cmd_i.char_code == CHAR_NEWLINE);
              state_q <= S_WRITE;
            end
          end
        end

        // one cell written, cursor advances
        S_WRITE: begin
          if (cur_col_q == LAST_COL) begin
            cur_col_q <= '0;
            if (cur_row_q == LAST_ROW) begin
              // top row scrolls off and becomes the new bottom row
              cur_prow_q <= top_q;
              top_q      <= (top_q == LAST_ROW) ? '0 : top_q + RW'(1);
              lin_q      <= BOTTOM_LIN;
              scroll_q   <= 1'b1;
              state_q    <= S_SCROLL;
            end else begin
              cur_row_q  <= cur_row_q + RW'(1);
              cur_prow_q <= (cur_prow_q == LAST_ROW) ? '0 : cur_prow_q + RW'(1);
              lin_q      <= lin_q + LW'(1);
              state_q    <= S_FINISH;
            end
          end else begin
            cur_col_q <= cur_col_q + CW'(1);
            lin_q     <= lin_q + LW'(1);
            if (!fill_q) state_q <= S_FINISH;
          end
        end

        S_BSWR: begin
          state_q <= S_FINISH;
        end

        // clear the new bottom row, column counter ends at zero
        S_SCROLL: begin
          if (cur_col_q == LAST_COL) begin
            cur_col_q <= '0;
            state_q   <= S_FINISH;
          end else begin
            cur_col_q <= cur_col_q + CW'(1);
          end
        end

        S_DIV: begin
          if (div_st.done) begin
            state_q <= div_st.in_range ? S_RD : S_FINISH;
          end
        end

        S_RD: begin
          state_q <= S_RDOUT;
        end

        S_RDOUT: begin
          state_q <= S_FINISH;
        end

        S_FINISH: begin
          state_q <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) begin
      code_q  <= cmd_i.char_code;
      rchar_q <= CHAR_NULL;
      rattr_q <= '0;
    end
    if (state_q == S_DIV && div_st.done) begin
      rd_prow_q <= rd_prow_d;
      rd_col_q  <= div_col;
    end
    if (state_q == S_RDOUT) begin
      rchar_q <= rdata_q[CHAR_W-1:0];
      rattr_q <= rdata_q[15:CHAR_W];
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_console_writer
// Drives put and read commands in random bursts and keeps its own copy of
// the screen, cursor and colors. Every result is checked field by field
// against the oldest prediction. Colors change between traffic phases.
// ----------------------------------------------------------------------------

// Screen predictor and result checker
class console_scoreboard #(int COLS = 80, int NROWS = 25);
  localparam int NCELLS = COLS * NROWS;

  logic [15:0]       screen [NCELLS];  // {attribute, char}
  int unsigned       cursor;
  logic [7:0]        text_color;
  logic [7:0]        blank_attr;
  tcw_pkg::tcw_out_t pending_results [$];
  int                errors;

  function new();
    foreach (screen[i]) screen[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_NULL};
    cursor     = 0;
    text_color = 8'd15;
    blank_attr = 8'd15;
    errors     = 0;
  endfunction

  function int outstanding();
    return pending_results.size();
  endfunction

  function void write_register(logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                               logic [tcw_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      tcw_pkg::REG_TEXT_COLOR: text_color = data;
      tcw_pkg::REG_BLANK_ATTR: blank_attr = data;
      default: ;
    endcase
  endfunction

  // Apply one accepted transaction to the screen copy, queue its result
  function void note_command(tcw_pkg::tcw_in_t cmd);
    tcw_pkg::tcw_out_t res;
    int                i;
    res = '0;
    if (cursor >= NCELLS) cursor = 0;
    if (cmd.command == tcw_pkg::CMD_READ) begin
      // out-of-range reads return zeros
      if (cmd.cell_index < NCELLS) begin
        res.read_char      = screen[cmd.cell_index][7:0];
        res.read_attribute = screen[cmd.cell_index][15:8];
      end
    end else begin
      case (cmd.char_code)
        tcw_pkg::CHAR_NEWLINE: begin
          // fill to end of line; a whole line when starting at column 0
          do begin
            screen[cursor] = {text_color, tcw_pkg::CHAR_SPACE};
            cursor++;
          end while (cursor % COLS != 0);
        end
        tcw_pkg::CHAR_BACKSPACE: begin
          if (cursor > 0) begin
            cursor--;
            screen[cursor] = {text_color, tcw_pkg::CHAR_SPACE};
          end
        end
        default: begin
          screen[cursor] = {text_color, cmd.char_code};
          cursor++;
        end
      endcase
      // ran off the end: shift rows up, clear the bottom row
      if (cursor >= NCELLS) begin
        for (i = 0; i < NCELLS - COLS; i++) screen[i] = screen[i + COLS];
        for (i = NCELLS - COLS; i < NCELLS; i++)
          screen[i] = {blank_attr, tcw_pkg::CHAR_NULL};
        cursor       = NCELLS - COLS;
        res.scrolled = 1'b1;
      end
    end
    res.cursor_position = cursor[tcw_pkg::IDX_W-1:0];
    pending_results.push_back(res);
  endfunction

  function void flag(string what, logic [15:0] exp_val, logic [15:0] act_val);
    errors++;
    $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h",
             $time, what, exp_val, act_val);
  endfunction

  // Compare one result transaction with the oldest prediction
  function void check_result(tcw_pkg::tcw_out_t act);
    tcw_pkg::tcw_out_t exp_res;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none actual %p", $time, act);
      return;
    end
    exp_res = pending_results.pop_front();
    if (act.cursor_position !== exp_res.cursor_position)
      flag("cursor_position", 16'(exp_res.cursor_position), 16'(act.cursor_position));
    if (act.read_char !== exp_res.read_char)
      flag("read_char", 16'(exp_res.read_char), 16'(act.read_char));
    if (act.read_attribute !== exp_res.read_attribute)
      flag("read_attribute", 16'(exp_res.read_attribute), 16'(act.read_attribute));
    if (act.scrolled !== exp_res.scrolled)
      flag("scrolled", 16'(exp_res.scrolled), 16'(act.scrolled));
  endfunction
endclass

module testbench;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int NCELLS  = COLUMNS * ROWS;
  localparam int PHASE_ITEMS = 175;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  tcw_in_t               cmd_i;
  logic                  done_o;
  tcw_out_t              result_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  console_scoreboard #(COLUMNS, ROWS) screen_sb;
  int burst_left;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Monitor: results first, since a result never belongs to this edge's input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) screen_sb.check_result(result_o);
      if (cfg_we_i) screen_sb.write_register(cfg_idx_i, cfg_data_i);
      if (start && !busy) screen_sb.note_command(cmd_i);
    end
  end

  // One transaction; bursts of random length with random gaps between them
  task automatic send_command(tcw_in_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    burst_left--;
  endtask

  task automatic send_put(logic [CHAR_W-1:0] code);
    tcw_in_t c;
    c.command    = CMD_PUT;
    c.char_code  = code;
    c.cell_index = IDX_W'($urandom_range(0, 2047));
    send_command(c);
  endtask

  task automatic send_read(int idx);
    tcw_in_t c;
    c.command    = CMD_READ;
    c.char_code  = CHAR_W'($urandom_range(0, 255));
    c.cell_index = IDX_W'(idx);
    send_command(c);
  endtask

  // Drain all results, let a trailing row clear finish
  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    while (screen_sb.outstanding() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (COLUMNS + 4) @(posedge clk_i);
  endtask

  task automatic set_colors(logic [7:0] text, logic [7:0] blank);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TEXT_COLOR;
    cfg_data_i <= text;
    @(posedge clk_i);
    cfg_idx_i  <= REG_BLANK_ATTR;
    cfg_data_i <= blank;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mixed traffic: runs of text, newlines and reads
  task automatic random_traffic(int n_items);
    int sent;
    int kind;
    int run;
    int k;
    int idx;
    logic [CHAR_W-1:0] code;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // a run of text, sometimes long enough to wrap lines
        run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 2 * COLUMNS : 20);
        for (k = 0; k < run; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            code = CHAR_BACKSPACE;
          end else begin
            do code = CHAR_W'($urandom_range(0, 255));
            while (code == CHAR_NEWLINE || code == CHAR_BACKSPACE);
          end
          send_put(code);
          sent++;
        end
      end else if (kind < 7) begin
        send_put(CHAR_NEWLINE);
        sent++;
      end else begin
        run = $urandom_range(1, 4);
        for (k = 0; k < run; k++) begin
          case ($urandom_range(0, 7))
            0:       idx = $urandom_range(NCELLS, 2047);
            1, 2, 3: idx = $urandom_range(0, NCELLS - 1);
            default: begin
              // around the cursor, where the recent writes are
              idx = int'(screen_sb.cursor) - int'($urandom_range(0, 3 * COLUMNS));
              if (idx < 0) idx = 0;
            end
          endcase
          send_read(idx);
          sent++;
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    screen_sb  = new();
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_TEXT_COLOR;
    cfg_data_i = '0;
    burst_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, range edges, each character class
    send_read(0);
    send_read(NCELLS - 1);
    send_read(NCELLS);
    send_read(2047);
    send_put(CHAR_BACKSPACE);      // at cell 0: no change
    send_put(8'h48);
    send_put(8'hFF);
    send_put(CHAR_NULL);
    send_put(CHAR_NEWLINE);        // mid-line fill
    send_put(CHAR_NEWLINE);        // from column 0: whole line
    send_put(8'h41);
    send_put(CHAR_BACKSPACE);
    send_put(CHAR_BACKSPACE);      // back onto the previous line
    send_read(0);
    send_read(1);
    send_read(2);
    send_read(COLUMNS - 1);
    send_read(COLUMNS);
    send_read(2 * COLUMNS - 1);
    send_read(2 * COLUMNS);
    send_read(3 * COLUMNS);

    // traffic phases under different colors, extremes included
    wait_idle();
    set_colors(8'h00, 8'hFF);
    random_traffic(PHASE_ITEMS);
    wait_idle();
    set_colors(8'hFF, 8'h00);
    random_traffic(PHASE_ITEMS);
    wait_idle();
    set_colors(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(PHASE_ITEMS);
    wait_idle();
    set_colors(8'h0F, 8'h0F);
    random_traffic(PHASE_ITEMS);

    // drain, then watch for stray results
    start <= 1'b0;
    while (screen_sb.outstanding() != 0) @(posedge clk_i);
    repeat (2 * COLUMNS + ROWS + 8) @(posedge clk_i);
    if (screen_sb.errors == 0 && screen_sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tcw_pkg.sv
design/tcw_div.sv
design/text_console_writer.sv
bench/testbench.sv
